/* design/pwcp_pkg.sv */
// Shared types and constants of the popularity weighted cache policy.
package pwcp_pkg;

   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_REQUEST = 3'd1;
   localparam logic [2:0] CMD_PROBE   = 3'd2;
   localparam logic [2:0] CMD_REMOVE  = 3'd3;
   localparam logic [2:0] CMD_EVICT   = 3'd4;
   localparam logic [2:0] CMD_SWEEP   = 3'd5;
   localparam logic [2:0] CMD_REBAL   = 3'd6;
   localparam logic [2:0] CMD_UNUSED  = 3'd7;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_MISS    = 2'd1;
   localparam logic [1:0] STAT_DROP    = 2'd2;
   localparam logic [1:0] STAT_PRESENT = 2'd3;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_EVICT  = 1'b1;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPIRY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOPLIMIT = 2'd2;

   localparam logic [39:0] CAPACITY_RESET = 40'd67108864;
   localparam logic [31:0] EXPIRY_RESET   = 32'd3600000;
   localparam logic [7:0]  HOPLIMIT_RESET = 8'd10;

   localparam logic [40:0] USED_MAX = {41{1'b1}};
   localparam logic [31:0] HITS_MAX = {32{1'b1}};

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] key;
      logic [31:0] item_size;
      logic [15:0] popularity;
      logic [7:0]  hops;
      logic [47:0] now_time;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] out_key;
      logic [1:0]  status;
      logic [31:0] hit_total;
      logic [40:0] bytes_in_use;
      logic [4:0]  entries_in_use;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] size;
      logic [15:0] popularity;
      logic [31:0] hits;
      logic [47:0] ins_time;
      logic [63:0] stamp;
   } slot_type;

endpackage

/* design/pwcp_slot_ram.sv */
// Slot record memory with one write port and one registered read port.
module pwcp_slot_ram import pwcp_pkg::*; #(
   parameter int ENTRIES = 16,
   localparam int IW = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  slot_type      wr_data,
   input  logic [IW-1:0] rd_addr,
   output slot_type      rd_data
);

   slot_type mem [ENTRIES];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pwcp_scan.sv */
// Scan unit that finds the matching key and the live slot with the lowest popularity-weighted score.
module pwcp_scan import pwcp_pkg::*; #(
   parameter int ENTRIES = 16,
   localparam int IW = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          ent_vld,
   input  logic [IW-1:0] ent_idx,
   input  logic          ent_live,
   input  slot_type      ent,
   input  logic [63:0]   key,
   output logic          done,
   output logic          found,
   output logic [IW-1:0] match_idx,
   output logic          vfound,
   output logic [IW-1:0] victim_idx
);

   logic          s1_vld_ff;
   logic [IW-1:0] s1_idx_ff;
   logic          s1_live_ff;
   logic          s1_match_ff;
   logic [47:0]   s1_score_ff;
   logic [63:0]   s1_stamp_ff;
   logic          done_ff;
   logic          found_ff;
   logic [IW-1:0] match_ff;
   logic          vfound_ff;
   logic [IW-1:0] victim_ff;
   logic [47:0]   best_ff;
   logic [63:0]   best_stamp_ff;
   logic [32:0]   hits_p1;
   logic [48:0]   prod;
   logic          better;

   assign hits_p1 = {1'b0, ent.hits} + 33'd1;
   assign prod = 49'(ent.popularity) * 49'(hits_p1);
   assign better = !vfound_ff || (s1_score_ff < best_ff) ||
                   ((s1_score_ff == best_ff) && (s1_stamp_ff < best_stamp_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
         vfound_ff <= 1'b0;
      end else if (start) begin
         s1_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
         vfound_ff <= 1'b0;
      end else begin
         s1_vld_ff <= ent_vld;
         if (s1_vld_ff && s1_live_ff) begin
            if (s1_match_ff) begin
               found_ff <= 1'b1;
               match_ff <= s1_idx_ff;
            end
            if (better) begin
               vfound_ff     <= 1'b1;
               victim_ff     <= s1_idx_ff;
               best_ff       <= s1_score_ff;
               best_stamp_ff <= s1_stamp_ff;
            end
         end
         if (s1_vld_ff && (s1_idx_ff == IW'(ENTRIES - 1))) begin
            done_ff <= 1'b1;
         end
      end
      s1_idx_ff   <= ent_idx;
      s1_live_ff  <= ent_live;
      s1_match_ff <= (ent.key == key);
      s1_score_ff <= prod[47:0];
      s1_stamp_ff <= ent.stamp;
   end

   assign done       = done_ff;
   assign found      = found_ff;
   assign match_idx  = match_ff;
   assign vfound     = vfound_ff;
   assign victim_idx = victim_ff;

endmodule

/* design/popularity_weighted_cache_policy.sv */
// Top level of the popularity weighted cache policy directory.
//
// A command enters on the req_ channel and is taken when req_valid is high
// and req_stall is low. The block works on one command at a time and holds
// req_stall high until the command's final answer is loaded into the output
// register. Results leave on the rsp_ channel: zero or more eviction notices,
// then one command answer with last set. A result waits in the output
// register while rsp_stall is high, and the sequencer pauses until it moves.
// Each command other than the expiry sweep begins with a scan of all slot
// records in the slot memory; the answer then goes to the output register,
// after a record fetch when the command needs one.
// Every eviction adds a record fetch and a notice, and for insert and
// rebalance another full scan. The expiry sweep visits the slots one by one.
// Reset empties the directory and loads the default capacity, expiry time
// and hop limit; the csr_ port writes them. The user must write them only
// while the block is idle; the block itself does not enforce this.
module popularity_weighted_cache_policy import pwcp_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [39:0]          csr_wdata
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RESCAN = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_SWAIT  = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_FETCH  = 4'd5;
   localparam logic [3:0] S_FDATA  = 4'd6;
   localparam logic [3:0] S_EMIT   = 4'd7;
   localparam logic [3:0] S_ANS2   = 4'd8;
   localparam logic [3:0] S_SWCHK  = 4'd9;
   localparam logic [3:0] S_SWNEXT = 4'd10;

   localparam logic [1:0] PH_MATCH = 2'd0;
   localparam logic [1:0] PH_EVICT = 2'd1;
   localparam logic [1:0] PH_SWEEP = 2'd2;

   logic [3:0]         state_ff, state_in;
   logic [3:0]         ret_ff, ret_in;
   logic [1:0]         phase_ff, phase_in;
   logic               first_ff, first_in;
   logic [IW-1:0]      sel_ff, sel_in;
   logic [IW-1:0]      scan_ctr_ff, scan_ctr_in;
   logic               scan_vld_ff;
   logic [IW-1:0]      scan_idx_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]      ent_ff, ent_in;
   logic [40:0]        used_ff, used_in;
   logic [63:0]        stamp_ff, stamp_in;
   req_type            op_ff;
   logic [39:0]        cap_ff;
   logic [31:0]        exp_ff;
   logic [7:0]         hlim_ff;
   logic               em_kind_ff, em_kind_in;
   logic [63:0]        em_key_ff, em_key_in;
   logic [1:0]         em_status_ff, em_status_in;
   logic [31:0]        em_hits_ff, em_hits_in;
   logic               em_last_ff, em_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               out_free;
   logic               scan_start;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   slot_type           wr_data;
   logic [IW-1:0]      rd_addr;
   slot_type           rd_data;
   logic               found;
   logic [IW-1:0]      match_idx;
   logic               vfound;
   logic [IW-1:0]      victim_idx;
   logic               scan_done;
   logic [IW-1:0]      free_idx;
   logic [41:0]        ins_sum;
   logic [44:0]        used10;
   logic [44:0]        cap9;
   logic [44:0]        cap7;
   logic [40:0]        drop_used;
   logic [47:0]        age;
   logic [31:0]        hits_inc;
   logic [CW+4:0]      ent_wide;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_start = (state_ff == S_RESCAN);
   assign rd_addr    = (state_ff == S_SCAN) ? scan_ctr_ff : sel_ff;

   assign ins_sum   = {1'b0, used_ff} + 42'(op_ff.item_size);
   assign used10    = 45'({used_ff, 3'b000}) + 45'({used_ff, 1'b0});
   assign cap9      = 45'({cap_ff, 3'b000}) + 45'(cap_ff);
   assign cap7      = 45'({cap_ff, 3'b000}) - 45'(cap_ff);
   assign drop_used = (used_ff >= 41'(rd_data.size)) ? used_ff - 41'(rd_data.size) : '0;
   assign age       = op_ff.now_time - rd_data.ins_time;
   assign hits_inc  = (rd_data.hits == HITS_MAX) ? rd_data.hits : rd_data.hits + 32'd1;
   assign ent_wide  = (CW + 5)'(ent_ff);

   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   pwcp_slot_ram #(.ENTRIES(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pwcp_scan #(.ENTRIES(ENTRIES)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .ent_vld    (scan_vld_ff),
      .ent_idx    (scan_idx_ff),
      .ent_live   (valid_ff[scan_idx_ff]),
      .ent        (rd_data),
      .key        (op_ff.key),
      .done       (scan_done),
      .found      (found),
      .match_idx  (match_idx),
      .vfound     (vfound),
      .victim_idx (victim_idx)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      phase_in     = phase_ff;
      first_in     = first_ff;
      sel_in       = sel_ff;
      scan_ctr_in  = scan_ctr_ff;
      valid_in     = valid_ff;
      ent_in       = ent_ff;
      used_in      = used_ff;
      stamp_in     = stamp_ff;
      em_kind_in   = em_kind_ff;
      em_key_in    = em_key_ff;
      em_status_in = em_status_ff;
      em_hits_in   = em_hits_ff;
      em_last_in   = em_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = sel_ff;
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               first_in = 1'b1;
               sel_in   = '0;
               state_in = (req_data.cmd == CMD_SWEEP) ? S_SWCHK : S_RESCAN;
            end
         end
         S_RESCAN: begin
            scan_ctr_in = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            scan_ctr_in = scan_ctr_ff + IW'(1);
            if (scan_ctr_ff == IW'(ENTRIES - 1)) begin
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            first_in     = 1'b0;
            em_kind_in   = KIND_ANSWER;
            em_key_in    = op_ff.key;
            em_status_in = STAT_MISS;
            em_hits_in   = '0;
            em_last_in   = 1'b1;
            ret_in       = S_IDLE;
            state_in     = S_EMIT;
            case (op_ff.cmd)
               CMD_INSERT: begin
                  if (found) begin
                     sel_in   = match_idx;
                     phase_in = PH_MATCH;
                     state_in = S_FETCH;
                  end else if ((ent_ff != '0) &&
                               ((ins_sum > 42'(cap_ff)) || (ent_ff >= CW'(ENTRIES)))) begin
                     sel_in   = victim_idx;
                     phase_in = PH_EVICT;
                     state_in = S_FETCH;
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = free_idx;
                     wr_data.key      = op_ff.key;
                     wr_data.size     = op_ff.item_size;
                     wr_data.popularity = op_ff.popularity;
                     wr_data.hits     = '0;
                     wr_data.ins_time = op_ff.now_time;
                     wr_data.stamp    = stamp_ff;
                     stamp_in         = stamp_ff + 64'd1;
                     valid_in[free_idx] = 1'b1;
                     ent_in           = ent_ff + CW'(1);
                     used_in          = ins_sum[41] ? USED_MAX : ins_sum[40:0];
                     em_status_in     = STAT_OK;
                  end
               end
               CMD_REQUEST: begin
                  if (op_ff.hops > hlim_ff) begin
                     em_status_in = STAT_DROP;
                  end else if (found) begin
                     sel_in   = match_idx;
                     phase_in = PH_MATCH;
                     state_in = S_FETCH;
                  end
               end
               CMD_PROBE, CMD_REMOVE: begin
                  if (found) begin
                     sel_in   = match_idx;
                     phase_in = PH_MATCH;
                     state_in = S_FETCH;
                  end
               end
               CMD_EVICT: begin
                  em_key_in = '0;
                  if (vfound) begin
                     sel_in   = victim_idx;
                     phase_in = PH_EVICT;
                     state_in = S_FETCH;
                  end
               end
               CMD_REBAL: begin
                  em_key_in    = '0;
                  em_status_in = STAT_OK;
                  if ((!first_ff || (used10 > cap9)) && (used10 > cap7) &&
                      (ent_ff != '0)) begin
                     sel_in   = victim_idx;
                     phase_in = PH_EVICT;
                     state_in = S_FETCH;
                  end
               end
               default: begin
               end
            endcase
         end
         S_FETCH: begin
            state_in = S_FDATA;
         end
         S_FDATA: begin
            em_kind_in   = KIND_ANSWER;
            em_key_in    = op_ff.key;
            em_status_in = STAT_OK;
            em_hits_in   = rd_data.hits;
            em_last_in   = 1'b1;
            ret_in       = S_IDLE;
            state_in     = S_EMIT;
            case (phase_ff)
               PH_MATCH: begin
                  case (op_ff.cmd)
                     CMD_INSERT: begin
                        wr_en         = 1'b1;
                        wr_data.stamp = stamp_ff;
                        stamp_in      = stamp_ff + 64'd1;
                        em_status_in  = STAT_PRESENT;
                     end
                     CMD_REQUEST: begin
                        wr_en         = 1'b1;
                        wr_data.hits  = hits_inc;
                        wr_data.stamp = stamp_ff;
                        stamp_in      = stamp_ff + 64'd1;
                        em_hits_in    = hits_inc;
                     end
                     CMD_REMOVE: begin
                        valid_in[sel_ff] = 1'b0;
                        ent_in           = ent_ff - CW'(1);
                        used_in          = drop_used;
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
                  if ((phase_ff == PH_EVICT) || ((rd_data.hits == '0) &&
                      (age > 48'(exp_ff)))) begin
                     valid_in[sel_ff] = 1'b0;
                     ent_in           = ent_ff - CW'(1);
                     used_in          = drop_used;
                     em_kind_in       = KIND_EVICT;
                     em_key_in        = rd_data.key;
                     em_last_in       = 1'b0;
                     if (phase_ff == PH_SWEEP) begin
                        ret_in = S_SWNEXT;
                     end else if (op_ff.cmd == CMD_EVICT) begin
                        ret_in = S_ANS2;
                     end else begin
                        ret_in = S_RESCAN;
                     end
                  end else begin
                     state_in = S_SWNEXT;
                  end
               end
            endcase
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.kind            = em_kind_ff;
               rsp_data_in.out_key         = em_key_ff;
               rsp_data_in.status          = em_status_ff;
               rsp_data_in.hit_total       = em_hits_ff;
               rsp_data_in.bytes_in_use    = used_ff;
               rsp_data_in.entries_in_use  = ent_wide[4:0];
               rsp_data_in.last            = em_last_ff;
               state_in                    = ret_ff;
            end
         end
         S_ANS2: begin
            em_kind_in = KIND_ANSWER;
            em_last_in = 1'b1;
            ret_in     = S_IDLE;
            state_in   = S_EMIT;
         end
         S_SWCHK: begin
            if (valid_ff[sel_ff]) begin
               phase_in = PH_SWEEP;
               state_in = S_FETCH;
            end else begin
               state_in = S_SWNEXT;
            end
         end
         S_SWNEXT: begin
            if (sel_ff == IW'(ENTRIES - 1)) begin
               em_kind_in   = KIND_ANSWER;
               em_key_in    = '0;
               em_status_in = STAT_OK;
               em_hits_in   = '0;
               em_last_in   = 1'b1;
               ret_in       = S_IDLE;
               state_in     = S_EMIT;
            end else begin
               sel_in   = sel_ff + IW'(1);
               state_in = S_SWCHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         first_ff     <= 1'b0;
         scan_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         ent_ff       <= '0;
         used_ff      <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
         exp_ff       <= EXPIRY_RESET;
         hlim_ff      <= HOPLIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         first_ff     <= first_in;
         scan_vld_ff  <= (state_ff == S_SCAN);
         valid_ff     <= valid_in;
         ent_ff       <= ent_in;
         used_ff      <= used_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff <= csr_wdata;
               CSR_EXPIRY: exp_ff <= csr_wdata[31:0];
               CSR_HOPLIMIT: hlim_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
      phase_ff     <= phase_in;
      sel_ff       <= sel_in;
      scan_ctr_ff  <= scan_ctr_in;
      scan_idx_ff  <= scan_ctr_ff;
      em_kind_ff   <= em_kind_in;
      em_key_ff    <= em_key_in;
      em_status_ff <= em_status_in;
      em_hits_ff   <= em_hits_in;
      em_last_ff   <= em_last_in;
      rsp_data_ff  <= rsp_data_in;
      if (accept) begin
         op_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'(ent_ff) == 32'($countones(valid_ff)))
      else $error("entry count disagrees with valid bits");

   a_fetch_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FDATA) |-> ($past(state_ff) == S_FETCH))
      else $error("record used without a fetch");

   a_last_is_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last) |-> (rsp_data_ff.kind == KIND_ANSWER))
      else $error("final transfer is not a command answer");

   a_idle_after_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && em_last_ff) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after final answer");

endmodule
